FILE: rtl/resistor_ladder_keypad_decoder_core_defines.svh
// Assertion macros shared by the keypad decoder RTL.
// No dependencies; included by files that carry assertions.
`ifndef RESISTOR_LADDER_KEYPAD_DECODER_CORE_DEFINES_SVH
`define RESISTOR_LADDER_KEYPAD_DECODER_CORE_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define KPD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keypad decoder check failed");

// next-cycle implication, ignored while in reset
`define KPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keypad decoder check failed");

`endif

FILE: rtl/kpd_pkg.sv
// Shared types, constants and the sample range table of the keypad decoder.
// No dependencies.
package kpd_pkg;

  localparam int KEY_CODES   = 13;
  localparam int SAMPLE_BITS = 10;
  localparam int RANGE_COUNT = 13;
  localparam int CODE_W      = 4;
  localparam int VOTE_W      = 8;
  localparam int IDX_W       = $clog2(KEY_CODES);
  localparam int CNT_W       = $clog2(KEY_CODES + 1);
  localparam int SPV_W       = 8;
  localparam int DELAY_W     = 20;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CODE_W-1:0] NO_KEY = CODE_W'(KEY_CODES - 1);

  // event kinds
  localparam logic [1:0] KIND_EDGE     = 2'd0;
  localparam logic [1:0] KIND_TIMER    = 2'd1;
  localparam logic [1:0] KIND_SAMPLE   = 2'd2;
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  // timer requests
  localparam logic [1:0] TREQ_NONE     = 2'd0;
  localparam logic [1:0] TREQ_DEBOUNCE = 2'd1;
  localparam logic [1:0] TREQ_RECHECK  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_VOTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_DELAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECHECK_DELAY    = 2'd2;

  localparam logic [SPV_W-1:0]   SPV_RESET      = 8'd4;
  localparam logic [DELAY_W-1:0] DEBOUNCE_RESET = 20'd20000;
  localparam logic [DELAY_W-1:0] RECHECK_RESET  = 20'd100000;

  localparam logic [SAMPLE_BITS-1:0] RANGE_LO [RANGE_COUNT] = '{
    10'd0, 10'd25, 10'd50, 10'd71, 10'd88, 10'd104, 10'd117,
    10'd130, 10'd140, 10'd149, 10'd158, 10'd166, 10'd181
  };
  localparam logic [SAMPLE_BITS-1:0] RANGE_HI [RANGE_COUNT] = '{
    10'd10, 10'd35, 10'd60, 10'd81, 10'd98, 10'd114, 10'd127,
    10'd140, 10'd150, 10'd159, 10'd168, 10'd176, 10'd255
  };

  typedef struct packed {
    logic [1:0]             kind;
    logic [SAMPLE_BITS-1:0] sample;
  } item_t;

  typedef struct packed {
    logic               start_conversion;
    logic               measure_mode;
    logic [1:0]         timer_request;
    logic [DELAY_W-1:0] timer_length_us;
    logic [CODE_W-1:0]  current_key;
    logic               key_decided;
  } result_t;

  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
  } match_t;

  // request from the event sequencer to the vote unit
  typedef struct packed {
    logic              start;
    logic              hit;
    logic [CODE_W-1:0] code;
    logic              vote;
  } vote_cmd_t;

  typedef struct packed {
    logic              done;
    logic [CODE_W-1:0] winner;
  } vote_sts_t;

  // first matching range wins: walk from the end so earlier entries override
  function automatic match_t match_sample(input logic [SAMPLE_BITS-1:0] v);
    match_t m;
    m.hit  = 1'b0;
    m.code = '0;
    for (int i = RANGE_COUNT - 1; i >= 0; i--) begin
      if (i < KEY_CODES && v >= RANGE_LO[i] && v <= RANGE_HI[i]) begin
        m.hit  = 1'b1;
        m.code = CODE_W'(i);
      end
    end
    return m;
  endfunction

endpackage

FILE: rtl/kpd_vote_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module kpd_vote_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/kpd_vote_unit.sv
// Vote counter store: increments one counter per matching sample and, on a vote, scans for the winner.
// Depends on kpd_pkg and kpd_vote_ram.
module kpd_vote_unit
  import kpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  vote_cmd_t cmd,
  output vote_sts_t sts
);

  typedef enum logic [1:0] {V_IDLE, V_INC, V_SCAN} vstate_t;

  vstate_t           state;
  logic              hit;
  logic [CODE_W-1:0] code;
  logic              vote;
  logic [KEY_CODES-1:0] valid;
  logic [CNT_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  cmp_idx;
  logic              cmp_valid;
  logic [VOTE_W-1:0] best;
  logic [CODE_W-1:0] win;

  logic              ram_we;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [VOTE_W-1:0] ram_rdata;
  logic [VOTE_W-1:0] inc_old;
  logic [VOTE_W-1:0] inc_new;
  logic              rd_issue;
  logic [VOTE_W-1:0] cur;
  logic              gt;
  logic              last;

  kpd_vote_ram #(.DEPTH(KEY_CODES), .WIDTH(VOTE_W)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(code[IDX_W-1:0]),
    .wdata(inc_new),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // entries not written since the last vote read as zero
  assign inc_old  = valid[code[IDX_W-1:0]] ? ram_rdata : '0;
  assign inc_new  = (inc_old == '1) ? inc_old : inc_old + 1'b1;
  assign ram_we   = (state == V_INC) && hit;
  assign rd_issue = (state == V_SCAN) && (rd_idx < CNT_W'(KEY_CODES));
  assign ram_re   = ((state == V_IDLE) && cmd.start) || rd_issue;
  assign ram_raddr = (state == V_SCAN) ? rd_idx[IDX_W-1:0] : cmd.code[IDX_W-1:0];

  assign cur  = valid[cmp_idx] ? ram_rdata : '0;
  assign gt   = cmp_valid && (cur > best);
  assign last = (state == V_SCAN) && cmp_valid && (cmp_idx == IDX_W'(KEY_CODES - 1));

  assign sts.done   = ((state == V_INC) && !vote) || last;
  assign sts.winner = gt ? CODE_W'(cmp_idx) : win;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= V_IDLE;
      valid     <= '0;
      cmp_valid <= 1'b0;
    end else begin
      case (state)
        V_IDLE: begin
          if (cmd.start) begin
            hit   <= cmd.hit;
            code  <= cmd.code;
            vote  <= cmd.vote;
            state <= V_INC;
          end
        end
        V_INC: begin
          if (hit) begin
            valid[code[IDX_W-1:0]] <= 1'b1;
          end
          if (vote) begin
            rd_idx    <= '0;
            cmp_valid <= 1'b0;
            best      <= '0;
            win       <= NO_KEY;
            state     <= V_SCAN;
          end else begin
            state <= V_IDLE;
          end
        end
        V_SCAN: begin
          // no read is issued in the last compare cycle, so this drops to zero there
          cmp_valid <= rd_issue;
          cmp_idx   <= rd_idx[IDX_W-1:0];
          if (rd_issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (gt) begin
            best <= cur;
            win  <= CODE_W'(cmp_idx);
          end
          if (last) begin
            valid <= '0;
            state <= V_IDLE;
          end
        end
        default: state <= V_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/resistor_ladder_keypad_decoder_core.sv
// Flow: edge, timer and ignored events pass the done phase to the result register;
// samples also pass the vote unit; one that closes a vote scans all 13 vote entries.
// One item in work at a time; a new item is taken while a result waits.
// Reset (synchronous): idle, interrupt mode, key none, counters and votes zero,
// registers at 4 / 20000 / 100000. No clearing pass: per-entry valid bits.
// Depends on kpd_pkg, kpd_vote_unit and the assertion macro header.
`include "resistor_ladder_keypad_decoder_core_defines.svh"

module resistor_ladder_keypad_decoder_core
  import kpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DELAY_W-1:0]   cfg_wdata
);

  typedef enum logic [1:0] {M_IDLE, M_CONVERT, M_WAIT} mode_t;
  typedef enum logic [1:0] {P_IDLE, P_VOTE, P_DONE} phase_t;

  mode_t              mode;
  phase_t             phase;
  logic [SPV_W-1:0]   samples_per_vote;
  logic [DELAY_W-1:0] debounce_delay;
  logic [DELAY_W-1:0] recheck_delay;
  logic [SPV_W-1:0]   sample_counter;
  logic [CODE_W-1:0]  decided_key;
  logic               ladder_driven;

  // result fields held until the output register is free
  logic               res_start;
  logic [1:0]         res_treq;
  logic [DELAY_W-1:0] res_tlen;
  logic               res_decided;
  logic               pend_vote;

  logic      accept;
  logic      is_vote;
  logic      edge_go;
  logic      timer_go;
  logic      sample_go;
  logic      debounce_go;
  logic      load;
  match_t    m;
  vote_cmd_t cmd;
  vote_sts_t sts;

  assign item_stall  = (phase != P_IDLE);
  assign accept      = item_valid && !item_stall;
  assign m           = match_sample(item.sample);
  assign is_vote     = (sample_counter >= samples_per_vote);
  assign edge_go     = (item.kind == KIND_EDGE) && (mode == M_IDLE);
  assign timer_go    = (item.kind == KIND_TIMER) && (mode == M_WAIT);
  assign sample_go   = (item.kind == KIND_SAMPLE) && (mode == M_CONVERT);
  assign debounce_go = sample_go && !is_vote;
  assign load        = (phase == P_DONE) && (!result_valid || !result_stall);

  assign cmd.start = accept && sample_go;
  assign cmd.hit   = m.hit;
  assign cmd.code  = m.code;
  assign cmd.vote  = is_vote;

  kpd_vote_unit u_vote (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .sts(sts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= M_IDLE;
      phase            <= P_IDLE;
      samples_per_vote <= SPV_RESET;
      debounce_delay   <= DEBOUNCE_RESET;
      recheck_delay    <= RECHECK_RESET;
      sample_counter   <= '0;
      decided_key      <= NO_KEY;
      ladder_driven    <= 1'b0;
      result_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLES_PER_VOTE: samples_per_vote <= cfg_wdata[SPV_W-1:0];
          CFG_DEBOUNCE_DELAY:   debounce_delay   <= cfg_wdata;
          CFG_RECHECK_DELAY:    recheck_delay    <= cfg_wdata;
          default: ;
        endcase
      end

      if (result_valid && !result_stall && !load) begin
        result_valid <= 1'b0;
      end

      case (phase)
        P_IDLE: begin
          if (accept) begin
            res_start   <= edge_go || timer_go;
            res_treq    <= debounce_go ? TREQ_DEBOUNCE : TREQ_NONE;
            res_tlen    <= debounce_go ? debounce_delay : '0;
            res_decided <= 1'b0;
            phase       <= sample_go ? P_VOTE : P_DONE;
            case (item.kind)
              KIND_EDGE: begin
                if (mode == M_IDLE) begin
                  ladder_driven  <= 1'b1;
                  sample_counter <= '0;
                  mode           <= M_CONVERT;
                end
              end
              KIND_TIMER: begin
                if (mode == M_WAIT) begin
                  mode <= M_CONVERT;
                end
              end
              KIND_SAMPLE: begin
                if (mode == M_CONVERT) begin
                  pend_vote <= is_vote;
                  if (is_vote) begin
                    sample_counter <= '0;
                  end else begin
                    sample_counter <= sample_counter + 1'b1;
                    mode           <= M_WAIT;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        P_VOTE: begin
          if (sts.done) begin
            phase <= P_DONE;
            if (pend_vote) begin
              decided_key <= sts.winner;
              res_decided <= 1'b1;
              if (sts.winner == NO_KEY) begin
                ladder_driven <= 1'b0;
                mode          <= M_IDLE;
              end else begin
                mode     <= M_WAIT;
                res_treq <= TREQ_RECHECK;
                res_tlen <= recheck_delay;
              end
            end
          end
        end
        P_DONE: begin
          if (load) begin
            result_valid            <= 1'b1;
            result.start_conversion <= res_start;
            result.measure_mode     <= ladder_driven;
            result.timer_request    <= res_treq;
            result.timer_length_us  <= res_tlen;
            result.current_key      <= decided_key;
            result.key_decided      <= res_decided;
            phase                   <= P_IDLE;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  `KPD_ASSERT_IMP(a_done_in_vote, sts.done, phase == P_VOTE)
  `KPD_ASSERT_IMP(a_start_measures, result_valid && result.start_conversion,
                  result.measure_mode)
  `KPD_ASSERT_IMP(a_recheck_has_key,
                  result_valid && result.timer_request == TREQ_RECHECK,
                  result.key_decided && result.current_key != NO_KEY)
  `KPD_ASSERT_IMP(a_no_timer_no_len,
                  result_valid && result.timer_request == TREQ_NONE,
                  result.timer_length_us == '0)
  `KPD_ASSERT_NEXT(a_vote_cmd_busy, cmd.start, phase == P_VOTE)

endmodule
